// ----- sv/fat_block_chain_engine_defines.svh -----
// Assertion macros used by the checker file.
`ifndef FAT_BLOCK_CHAIN_ENGINE_DEFINES_SVH
`define FAT_BLOCK_CHAIN_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBCE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FBCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/fbce_pkg.sv -----
// ----------------------------------------------------------------------------
// fbce_pkg
// Types and constants shared by the block chain engine modules.
// ----------------------------------------------------------------------------
package fbce_pkg;

  localparam logic [15:0] LENGTH_LIMIT = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_READ   = 2'd2,
    ACT_DELETE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DROPPED   = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_BEYOND    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    LEN_ZERO,
    LEN_REC,
    LEN_INC
  } len_sel_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_SRD, S_SCK, S_DISP, S_BRD, S_BCK, S_CMK, S_AL1, S_AL2,
    S_AWR, S_RCHK, S_RNXT, S_RBYTE, S_DRD, S_DCK, S_DONE
  } state_t;

  typedef struct packed {
    logic     clr;
    logic     lat;
    logic     idx_clr;
    logic     idx_inc;
    logic     s_ck;
    logic     b_rd;
    logic     b_ck;
    logic     mk_create;
    logic     link_tail;
    logic     link_new;
    logic     a_wr;
    logic     walk_init;
    logic     r_nxt;
    logic     d_ck;
    logic     res_we;
    logic     res_byte;
    status_t  res_status;
    len_sel_t res_len;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    c_last;
    logic    s_last;
    logic    b_last;
    logic    s_hit;
    logic    found;
    logic    free_slot;
    logic    b_free;
    logic    len_max;
    logic    fill_full;
    logic    len_zero;
    logic    beyond;
    logic    rem_ge;
    logic    is_end;
  } sts_t;

endpackage

// ----- sv/fbce_ram.sv -----
// ----------------------------------------------------------------------------
// fbce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/fbce_ctrl.sv -----
// ----------------------------------------------------------------------------
// fbce_ctrl
// Sequencer for the block chain engine: scans, chain walks and result strobe.
// ----------------------------------------------------------------------------
module fbce_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  fbce_pkg::sts_t sts,
  output fbce_pkg::cmd_t cmd,
  output logic           busy,
  output logic           done
);

  fbce_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbce_pkg::S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fbce_pkg::S_CLR:   if (sts.c_last) state_next = fbce_pkg::S_IDLE;
      fbce_pkg::S_IDLE:  if (start) state_next = fbce_pkg::S_SRD;
      fbce_pkg::S_SRD:   state_next = fbce_pkg::S_SCK;
      fbce_pkg::S_SCK: begin
        if (sts.s_hit || sts.s_last) state_next = fbce_pkg::S_DISP;
        else state_next = fbce_pkg::S_SRD;
      end
      fbce_pkg::S_DISP: begin
        state_next = fbce_pkg::S_DONE;
        if (!sts.found) begin
          if (sts.act == fbce_pkg::ACT_CREATE && sts.free_slot) state_next = fbce_pkg::S_BRD;
        end else begin
          unique case (sts.act)
            fbce_pkg::ACT_CREATE: state_next = fbce_pkg::S_DONE;
            fbce_pkg::ACT_APPEND: begin
              if (sts.len_max) state_next = fbce_pkg::S_DONE;
              else if (sts.fill_full) state_next = fbce_pkg::S_BRD;
              else state_next = fbce_pkg::S_AWR;
            end
            fbce_pkg::ACT_READ: begin
              if (!sts.len_zero && !sts.beyond) state_next = fbce_pkg::S_RCHK;
            end
            fbce_pkg::ACT_DELETE: state_next = fbce_pkg::S_DRD;
            default: state_next = fbce_pkg::S_DONE;
          endcase
        end
      end
      fbce_pkg::S_BRD:   state_next = fbce_pkg::S_BCK;
      fbce_pkg::S_BCK: begin
        if (sts.b_free) begin
          state_next = (sts.act == fbce_pkg::ACT_CREATE) ? fbce_pkg::S_CMK : fbce_pkg::S_AL1;
        end else if (sts.b_last) begin
          state_next = fbce_pkg::S_DONE;
        end else begin
          state_next = fbce_pkg::S_BRD;
        end
      end
      fbce_pkg::S_CMK:   state_next = fbce_pkg::S_DONE;
      fbce_pkg::S_AL1:   state_next = fbce_pkg::S_AL2;
      fbce_pkg::S_AL2:   state_next = fbce_pkg::S_AWR;
      fbce_pkg::S_AWR:   state_next = fbce_pkg::S_DONE;
      fbce_pkg::S_RCHK:  state_next = sts.rem_ge ? fbce_pkg::S_RNXT : fbce_pkg::S_RBYTE;
      fbce_pkg::S_RNXT:  state_next = fbce_pkg::S_RCHK;
      fbce_pkg::S_RBYTE: state_next = fbce_pkg::S_DONE;
      fbce_pkg::S_DRD:   state_next = fbce_pkg::S_DCK;
      fbce_pkg::S_DCK:   state_next = sts.is_end ? fbce_pkg::S_DONE : fbce_pkg::S_DRD;
      fbce_pkg::S_DONE:  state_next = fbce_pkg::S_IDLE;
      default:           state_next = fbce_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.res_status = fbce_pkg::ST_OK;
    cmd.res_len    = fbce_pkg::LEN_ZERO;
    busy           = (state != fbce_pkg::S_IDLE);
    done           = (state == fbce_pkg::S_DONE);
    unique case (state)
      fbce_pkg::S_CLR: begin
        cmd.clr     = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      fbce_pkg::S_IDLE: begin
        cmd.lat     = start;
        cmd.idx_clr = start;
      end
      fbce_pkg::S_SCK: begin
        cmd.s_ck    = 1'b1;
        cmd.idx_inc = !sts.s_hit && !sts.s_last;
      end
      fbce_pkg::S_DISP: begin
        cmd.res_we = 1'b1;
        if (!sts.found) begin
          if (sts.act == fbce_pkg::ACT_CREATE) begin
            if (sts.free_slot) begin
              cmd.res_we  = 1'b0;
              cmd.idx_clr = 1'b1;
            end else begin
              cmd.res_status = fbce_pkg::ST_FULL;
            end
          end else begin
            cmd.res_status = fbce_pkg::ST_NOT_FOUND;
          end
        end else begin
          cmd.res_len = fbce_pkg::LEN_REC;
          unique case (sts.act)
            fbce_pkg::ACT_CREATE: cmd.res_status = fbce_pkg::ST_EXISTS;
            fbce_pkg::ACT_APPEND: begin
              if (sts.len_max) begin
                cmd.res_status = fbce_pkg::ST_DROPPED;
              end else begin
                cmd.res_we  = 1'b0;
                cmd.idx_clr = sts.fill_full;
              end
            end
            fbce_pkg::ACT_READ: begin
              if (sts.len_zero) begin
                cmd.res_status = fbce_pkg::ST_EMPTY;
              end else if (sts.beyond) begin
                cmd.res_status = fbce_pkg::ST_BEYOND;
              end else begin
                cmd.res_we    = 1'b0;
                cmd.walk_init = 1'b1;
              end
            end
            fbce_pkg::ACT_DELETE: begin
              cmd.res_we    = 1'b0;
              cmd.walk_init = 1'b1;
            end
            default: cmd.res_we = 1'b0;
          endcase
        end
      end
      fbce_pkg::S_BRD: cmd.b_rd = 1'b1;
      fbce_pkg::S_BCK: begin
        cmd.b_ck = 1'b1;
        if (!sts.b_free) begin
          if (sts.b_last) begin
            cmd.res_we     = 1'b1;
            cmd.res_status = fbce_pkg::ST_FULL;
            cmd.res_len    = (sts.act == fbce_pkg::ACT_CREATE) ? fbce_pkg::LEN_ZERO
                                                               : fbce_pkg::LEN_REC;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      fbce_pkg::S_CMK: begin
        cmd.mk_create = 1'b1;
        cmd.res_we    = 1'b1;
      end
      fbce_pkg::S_AL1: cmd.link_tail = 1'b1;
      fbce_pkg::S_AL2: cmd.link_new = 1'b1;
      fbce_pkg::S_AWR: begin
        cmd.a_wr    = 1'b1;
        cmd.res_we  = 1'b1;
        cmd.res_len = fbce_pkg::LEN_INC;
      end
      fbce_pkg::S_RNXT: cmd.r_nxt = 1'b1;
      fbce_pkg::S_RBYTE: begin
        cmd.res_we   = 1'b1;
        cmd.res_byte = 1'b1;
        cmd.res_len  = fbce_pkg::LEN_REC;
      end
      fbce_pkg::S_DCK: begin
        cmd.d_ck   = 1'b1;
        cmd.res_we = sts.is_end;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/fbce_dp.sv -----
// ----------------------------------------------------------------------------
// fbce_dp
// Datapath: directory, link table and byte store, with scan and walk registers.
// ----------------------------------------------------------------------------
module fbce_dp #(
  parameter int BLOCK_COUNT     = 1024,
  parameter int BYTES_PER_BLOCK = 32,
  parameter int SLOT_COUNT      = 128,
  parameter int TAG_BITS        = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  fbce_pkg::cmd_t cmd,
  output fbce_pkg::sts_t sts,
  input  logic [1:0]     action,
  input  logic [31:0]    name_tag,
  input  logic [7:0]     data_byte,
  input  logic [14:0]    byte_offset,
  output logic [2:0]     status,
  output logic [7:0]     read_byte,
  output logic [15:0]    file_length
);

  localparam int BW    = $clog2(BLOCK_COUNT);
  localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CLR_N = (BLOCK_COUNT > SLOT_COUNT) ? BLOCK_COUNT : SLOT_COUNT;
  localparam int CW    = $clog2(CLR_N);
  localparam int TW    = (TAG_BITS < 32) ? TAG_BITS : 32;
  localparam int FW    = $clog2(BYTES_PER_BLOCK + 1);
  localparam int BYTES = BLOCK_COUNT * BYTES_PER_BLOCK;
  localparam int YW    = (BYTES > 1) ? $clog2(BYTES) : 1;

  typedef struct packed {
    logic          used;
    logic          is_end;
    logic [BW-1:0] nxt;
  } blk_word_t;

  typedef struct packed {
    logic          valid;
    logic [TW-1:0] tag;
    logic [BW-1:0] first;
    logic [BW-1:0] tail;
    logic [15:0]   len;
    logic [FW-1:0] fill;
  } slot_word_t;

  logic [CW-1:0]     idx;
  fbce_pkg::action_t act;
  logic [TW-1:0]     tag;
  logic [7:0]        dbyte;
  logic [14:0]       offs;
  logic              found;
  logic              free_found;
  logic [SW-1:0]     sidx;
  logic [SW-1:0]     fslot;
  slot_word_t        rec;
  logic [BW-1:0]     newb;
  logic [BW-1:0]     blk;
  logic [14:0]       rem;

  blk_word_t  b_rdata, b_wdata;
  slot_word_t s_rdata, s_wdata;
  logic [BW-1:0] b_waddr, b_raddr;
  logic [SW-1:0] s_waddr;
  logic          b_we, s_we;
  logic [YW-1:0] y_waddr, y_raddr;
  logic [7:0]    y_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lat) begin
      act        <= fbce_pkg::action_t'(action);
      tag        <= name_tag[TW-1:0];
      dbyte      <= data_byte;
      offs       <= byte_offset;
      found      <= 1'b0;
      free_found <= 1'b0;
    end
    if (cmd.s_ck) begin
      if (sts.s_hit) begin
        found <= 1'b1;
        sidx  <= idx[SW-1:0];
        rec   <= s_rdata;
      end else if (!s_rdata.valid && !free_found) begin
        free_found <= 1'b1;
        fslot      <= idx[SW-1:0];
      end
    end
    if (cmd.b_ck && !b_rdata.used) begin
      newb <= idx[BW-1:0];
    end
    if (cmd.link_new) begin
      rec.tail <= newb;
      rec.fill <= '0;
    end
    if (cmd.walk_init) begin
      blk <= rec.first;
      rem <= offs;
    end
    if (cmd.r_nxt) begin
      blk <= b_rdata.nxt;
      rem <= rem - 15'(BYTES_PER_BLOCK);
    end
    if (cmd.d_ck) begin
      blk <= b_rdata.nxt;
    end
    if (cmd.res_we) begin
      status    <= cmd.res_status;
      read_byte <= cmd.res_byte ? y_rdata : 8'd0;
      case (cmd.res_len)
        fbce_pkg::LEN_REC: file_length <= rec.len;
        fbce_pkg::LEN_INC: file_length <= rec.len + 16'd1;
        default:           file_length <= 16'd0;
      endcase
    end
  end

  always_comb begin
    sts.act       = act;
    sts.c_last    = (idx == CW'(CLR_N - 1));
    sts.s_last    = (idx == CW'(SLOT_COUNT - 1));
    sts.b_last    = (idx == CW'(BLOCK_COUNT - 1));
    sts.s_hit     = s_rdata.valid && (s_rdata.tag == tag);
    sts.found     = found;
    sts.free_slot = free_found;
    sts.b_free    = !b_rdata.used;
    sts.len_max   = (rec.len >= fbce_pkg::LENGTH_LIMIT);
    sts.fill_full = (rec.fill == FW'(BYTES_PER_BLOCK));
    sts.len_zero  = (rec.len == 16'd0);
    sts.beyond    = ({1'b0, offs} >= rec.len);
    sts.rem_ge    = (rem >= 15'(BYTES_PER_BLOCK));
    sts.is_end    = b_rdata.is_end;
  end

  // Link table writes; the clearing pass only touches indexes inside the table.
  always_comb begin
    b_we    = 1'b0;
    b_waddr = blk;
    b_wdata = '0;
    if (cmd.clr) begin
      b_we    = (idx <= CW'(BLOCK_COUNT - 1));
      b_waddr = idx[BW-1:0];
    end else if (cmd.mk_create || cmd.link_new) begin
      b_we    = 1'b1;
      b_waddr = newb;
      b_wdata = '{used: 1'b1, is_end: 1'b1, nxt: '0};
    end else if (cmd.link_tail) begin
      b_we    = 1'b1;
      b_waddr = rec.tail;
      b_wdata = '{used: 1'b1, is_end: 1'b0, nxt: newb};
    end else if (cmd.d_ck) begin
      b_we    = 1'b1;
    end
    b_raddr = cmd.b_rd ? idx[BW-1:0] : blk;
  end

  always_comb begin
    s_we    = 1'b0;
    s_waddr = sidx;
    s_wdata = '0;
    if (cmd.clr) begin
      s_we    = (idx <= CW'(SLOT_COUNT - 1));
      s_waddr = idx[SW-1:0];
    end else if (cmd.mk_create) begin
      s_we    = 1'b1;
      s_waddr = fslot;
      s_wdata = '{valid: 1'b1, tag: tag, first: newb, tail: newb, len: 16'd0, fill: '0};
    end else if (cmd.a_wr) begin
      s_we    = 1'b1;
      s_wdata = '{valid: 1'b1, tag: tag, first: rec.first, tail: rec.tail,
                  len: rec.len + 16'd1, fill: rec.fill + 1'b1};
    end else if (cmd.d_ck) begin
      s_we    = b_rdata.is_end;
    end
  end

  assign y_waddr = YW'(YW'(rec.tail) * YW'(BYTES_PER_BLOCK) + YW'(rec.fill));
  assign y_raddr = YW'(YW'(blk) * YW'(BYTES_PER_BLOCK) + YW'(rem));

  fbce_ram #(.WIDTH($bits(blk_word_t)), .DEPTH(BLOCK_COUNT)) u_link_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  fbce_ram #(.WIDTH($bits(slot_word_t)), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(idx[SW-1:0]), .rdata(s_rdata)
  );

  fbce_ram #(.WIDTH(8), .DEPTH(BYTES)) u_byte_ram (
    .clk(clk), .we(cmd.a_wr), .waddr(y_waddr), .wdata(dbyte),
    .raddr(y_raddr), .rdata(y_rdata)
  );

endmodule

// ----- sv/fat_block_chain_engine.sv -----
// ----------------------------------------------------------------------------
// fat_block_chain_engine
// File allocation table engine: create, append byte, read byte and delete.
// ----------------------------------------------------------------------------
// After reset the engine runs a clearing pass over the link table and the
// directory with busy high. A transaction is taken when start is high and
// busy is low; busy then stays high until the result has been shown on done
// for one cycle, and the receiver cannot stall. A transaction runs a directory
// search over up to SLOT_COUNT slots, plus a lowest-free-block scan over up to
// BLOCK_COUNT blocks on create or on an append that opens a block, one block
// hop per block passed on a read, and one step per block freed on delete;
// each step is one read of a registered-output memory followed by a check.
module fat_block_chain_engine #(
  parameter int BLOCK_COUNT     = 1024,
  parameter int BYTES_PER_BLOCK = 32,
  parameter int SLOT_COUNT      = 128,
  parameter int TAG_BITS        = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [31:0] name_tag,
  input  logic [7:0]  data_byte,
  input  logic [14:0] byte_offset,
  output logic        done,
  output logic [2:0]  status,
  output logic [7:0]  read_byte,
  output logic [15:0] file_length
);

  fbce_pkg::cmd_t cmd;
  fbce_pkg::sts_t sts;

  fbce_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .cmd(cmd),
    .busy(busy), .done(done)
  );

  fbce_dp #(
    .BLOCK_COUNT(BLOCK_COUNT), .BYTES_PER_BLOCK(BYTES_PER_BLOCK),
    .SLOT_COUNT(SLOT_COUNT), .TAG_BITS(TAG_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .action(action), .name_tag(name_tag), .data_byte(data_byte),
    .byte_offset(byte_offset), .status(status), .read_byte(read_byte),
    .file_length(file_length)
  );

endmodule

// ----- sv/fbce_chk.sv -----
// ----------------------------------------------------------------------------
// fbce_chk
// Port-level checks on the block chain engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "fat_block_chain_engine_defines.svh"

module fbce_chk (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status,
  input logic [7:0]  read_byte,
  input logic [15:0] file_length
);

  // A result only comes out of a transaction in progress.
  `FBCE_ASSERT_NOW(a_done_busy, clk, rst, done, busy)
  // An accepted transaction makes the engine busy in the next cycle.
  `FBCE_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // The result strobe lasts one cycle and the engine is free right after.
  `FBCE_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done && !busy)
  // A failed transaction reports no data byte.
  `FBCE_ASSERT_NOW(a_fail_zero, clk, rst,
    done && (status != 3'(fbce_pkg::ST_OK)), read_byte == 8'd0)

endmodule

bind fat_block_chain_engine fbce_chk u_fbce_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .read_byte(read_byte), .file_length(file_length)
);
